[design/vrf_pkg.sv]
// Shared constants, codes and types of the VLIW register file.
`timescale 1ns / 1ps
package vrf_pkg;

    // Storage sizes.
    localparam int NUM_GP_REGS   = 64;
    localparam int NUM_PRED_REGS = 8;
    localparam int DATA_WIDTH    = 32;
    localparam int GP_AW         = $clog2(NUM_GP_REGS);
    localparam int PRED_AW       = $clog2(NUM_PRED_REGS);

    // Field widths of a transaction.
    localparam int REG_IDX_W  = 6;
    localparam int PRED_IDX_W = 3;
    localparam int INSTR_W    = 32;
    localparam int BLEN_W     = 8;
    localparam int WB_SRC_W   = 2;

    // Instruction word predecode positions.
    localparam int SRC1_LSB  = 0;
    localparam int SRC2_LSB  = 6;
    localparam int SCOND_LSB = 21;
    localparam int BCOND_LSB = 23;

    // Predicate register that is always returned on a read.
    localparam int FIXED_PRED_IDX = 4;

    typedef enum logic {
        MODE_READ  = 1'b0,
        MODE_WRITE = 1'b1
    } t_mode;

    typedef enum logic [WB_SRC_W-1:0] {
        WB_ALU     = 2'd0,
        WB_MEM     = 2'd1,
        WB_LINK    = 2'd2,
        WB_INVALID = 2'd3
    } t_wb_src;

    // Write request into the general register bank.
    typedef struct packed {
        logic                  en;
        logic [GP_AW-1:0]      addr;
        logic [DATA_WIDTH-1:0] data;
    } t_gp_wr;

    // Dual read request into the general register bank.
    typedef struct packed {
        logic             en;
        logic [GP_AW-1:0] addr1;
        logic             ok1;
        logic [GP_AW-1:0] addr2;
        logic             ok2;
    } t_gp_rd;

endpackage

[design/vrf_ifs.sv]
// Handshake interfaces for the slot operation and result channels.
`timescale 1ns / 1ps
interface vrf_op_if;
    import vrf_pkg::*;

    logic                          valid;
    logic                          ready;
    logic                          mode;
    logic [INSTR_W-1:0]            instr_word;
    logic [REG_IDX_W-1:0]          dest_reg;
    logic                          reg_write;
    logic                          pred_write;
    logic [PRED_IDX_W-1:0]         pred_dest;
    logic [WB_SRC_W-1:0]           wb_source;
    logic signed [DATA_WIDTH-1:0]  alu_value;
    logic                          alu_pred;
    logic signed [DATA_WIDTH-1:0]  mem_value;
    logic [DATA_WIDTH-1:0]         pc_value;
    logic [BLEN_W-1:0]             bundle_len;

    modport source (
        output valid, mode, instr_word, dest_reg, reg_write, pred_write, pred_dest,
               wb_source, alu_value, alu_pred, mem_value, pc_value, bundle_len,
        input  ready
    );
    modport sink (
        input  valid, mode, instr_word, dest_reg, reg_write, pred_write, pred_dest,
               wb_source, alu_value, alu_pred, mem_value, pc_value, bundle_len,
        output ready
    );
endinterface

interface vrf_res_if;
    import vrf_pkg::*;

    logic                          valid;
    logic                          ready;
    logic signed [DATA_WIDTH-1:0]  src1_value;
    logic signed [DATA_WIDTH-1:0]  src2_value;
    logic                          bcond_value;
    logic                          scond_value;
    logic                          fpred_value;

    modport source (
        output valid, src1_value, src2_value, bcond_value, scond_value, fpred_value,
        input  ready
    );
    modport sink (
        input  valid, src1_value, src2_value, bcond_value, scond_value, fpred_value,
        output ready
    );
endinterface

[design/vrf_ram.sv]
// Generic single write port RAM with one registered read port.
`timescale 1ns / 1ps
module vrf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

[design/vrf_gp_bank.sv]
// General register bank: two RAM copies for two reads, valid bits for reset.
`timescale 1ns / 1ps
module vrf_gp_bank (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  vrf_pkg::t_gp_wr               i_wr,
    input  vrf_pkg::t_gp_rd               i_rd,
    output logic [vrf_pkg::DATA_WIDTH-1:0] o_rd1_data,
    output logic [vrf_pkg::DATA_WIDTH-1:0] o_rd2_data
);
    import vrf_pkg::*;

    logic [NUM_GP_REGS-1:0] r_valid;
    logic                   r_hit1;
    logic                   r_hit2;
    logic [DATA_WIDTH-1:0]  w_q1;
    logic [DATA_WIDTH-1:0]  w_q2;

    vrf_ram #(.WIDTH(DATA_WIDTH), .DEPTH(NUM_GP_REGS)) u_ram1 (
        .i_clk   (i_clk),
        .i_we    (i_wr.en),
        .i_waddr (i_wr.addr),
        .i_wdata (i_wr.data),
        .i_re    (i_rd.en),
        .i_raddr (i_rd.addr1),
        .o_rdata (w_q1)
    );

    vrf_ram #(.WIDTH(DATA_WIDTH), .DEPTH(NUM_GP_REGS)) u_ram2 (
        .i_clk   (i_clk),
        .i_we    (i_wr.en),
        .i_waddr (i_wr.addr),
        .i_wdata (i_wr.data),
        .i_re    (i_rd.en),
        .i_raddr (i_rd.addr2),
        .o_rdata (w_q2)
    );

    // An entry not written since reset reads as zero.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_wr.en) begin
            r_valid[i_wr.addr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd.en) begin
            r_hit1 <= i_rd.ok1 && r_valid[i_rd.addr1];
            r_hit2 <= i_rd.ok2 && r_valid[i_rd.addr2];
        end
    end

    assign o_rd1_data = r_hit1 ? w_q1 : '0;
    assign o_rd2_data = r_hit2 ? w_q2 : '0;
endmodule

[design/vliw_register_file_with_predicates.sv]
// Top level of the VLIW register file with predicate registers.
`timescale 1ns / 1ps
// This block holds the 64 general registers of 32 bits and the 8 one-bit
// predicate registers of one issue slot's view of the core. Each transaction
// on the operation channel is either an operand read, which predecodes the
// instruction word and returns both source registers, the predicates picked
// by the bcond and scond fields and the fixed predicate four, or a write-back,
// which returns an all-zero result. A write-back stores the ALU result, the
// memory result or the call link (pc plus bundle size, wrapping at 32 bits)
// into a nonzero destination, and stores the ALU predicate only when the ALU
// is the source; the invalid source code writes no general register. The block
// takes one transaction in every cycle unless backpressure holds it. An
// accepted transaction loads both the read stage and the registered read port
// of the register RAM; the result register loads from them once it is empty
// or its content is taken, and then offers the result. While a finished
// result waits under backpressure, the read stage still takes one more
// transaction; the operation channel stalls only when both the read stage
// and the result register are full. The general registers read as zero after
// reset through per-entry valid bits and the predicates are cleared directly;
// no clearing pass is needed; the block is ready once reset is released.
module vliw_register_file_with_predicates (
    input  logic   i_clk,
    input  logic   i_rst_n,
    vrf_op_if.sink   i_op,
    vrf_res_if.source o_res
);
    import vrf_pkg::*;

    // Handshake and stage control.
    logic w_accept;
    logic w_out_load;
    logic w_s1_move;

    // Predecoded instruction fields.
    logic [REG_IDX_W-1:0]  w_src1;
    logic [REG_IDX_W-1:0]  w_src2;
    logic [PRED_IDX_W-1:0] w_scond;
    logic [PRED_IDX_W-1:0] w_bcond;
    logic                  w_is_write;
    t_wb_src               w_src;

    // Bank requests and read data.
    t_gp_wr                w_gp_wr;
    t_gp_rd                w_gp_rd;
    logic [DATA_WIDTH-1:0] w_rd1;
    logic [DATA_WIDTH-1:0] w_rd2;
    logic [DATA_WIDTH-1:0] w_wdata;

    logic [NUM_PRED_REGS-1:0] r_pred;

    // Read stage: holds the transaction while the RAM data is presented.
    logic r_s1_valid;
    logic r_s1_write;
    logic r_s1_bcond;
    logic r_s1_scond;
    logic r_s1_fpred;

    // Result register.
    logic                         r_out_valid;
    logic signed [DATA_WIDTH-1:0] r_out_src1;
    logic signed [DATA_WIDTH-1:0] r_out_src2;
    logic                         r_out_bcond;
    logic                         r_out_scond;
    logic                         r_out_fpred;

    // The result register loads when it is empty or its content is taken;
    // the read stage accepts whenever it is empty or can move forward.
    assign w_out_load = !r_out_valid || o_res.ready;
    assign w_s1_move  = r_s1_valid && w_out_load;
    assign i_op.ready = !r_s1_valid || w_out_load;
    assign w_accept   = i_op.valid && i_op.ready;

    assign w_is_write = (i_op.mode == MODE_WRITE);
    assign w_src      = t_wb_src'(i_op.wb_source);

    assign w_src1  = i_op.instr_word[SRC1_LSB  +: REG_IDX_W];
    assign w_src2  = i_op.instr_word[SRC2_LSB  +: REG_IDX_W];
    assign w_scond = i_op.instr_word[SCOND_LSB +: PRED_IDX_W];
    assign w_bcond = i_op.instr_word[BCOND_LSB +: PRED_IDX_W];

    // Write-back data selection; the invalid code is blocked in the enable.
    always_comb begin
        case (w_src)
            WB_ALU:  w_wdata = i_op.alu_value;
            WB_MEM:  w_wdata = i_op.mem_value;
            WB_LINK: w_wdata = i_op.pc_value + {{(DATA_WIDTH-BLEN_W){1'b0}}, i_op.bundle_len};
            default: w_wdata = '0;
        endcase
    end

    // Register zero is never written, and indexes beyond the file are ignored.
    always_comb begin
        w_gp_wr.en   = w_accept && w_is_write && i_op.reg_write
                       && (i_op.dest_reg != '0)
                       && ((REG_IDX_W+1)'(i_op.dest_reg) < (REG_IDX_W+1)'(NUM_GP_REGS))
                       && (w_src != WB_INVALID);
        w_gp_wr.addr = i_op.dest_reg[GP_AW-1:0];
        w_gp_wr.data = w_wdata;

        w_gp_rd.en    = w_accept;
        w_gp_rd.addr1 = w_src1[GP_AW-1:0];
        w_gp_rd.ok1   = ((REG_IDX_W+1)'(w_src1) < (REG_IDX_W+1)'(NUM_GP_REGS));
        w_gp_rd.addr2 = w_src2[GP_AW-1:0];
        w_gp_rd.ok2   = ((REG_IDX_W+1)'(w_src2) < (REG_IDX_W+1)'(NUM_GP_REGS));
    end

    vrf_gp_bank u_gp_bank (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr       (w_gp_wr),
        .i_rd       (w_gp_rd),
        .o_rd1_data (w_rd1),
        .o_rd2_data (w_rd2)
    );

    // Predicates are written only when the ALU is the write-back source.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pred <= '0;
        end else if (w_accept && w_is_write && i_op.pred_write && (w_src == WB_ALU)) begin
            r_pred[i_op.pred_dest[PRED_AW-1:0]] <= i_op.alu_pred;
        end
    end

    // Read stage control and payload.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_accept) begin
            r_s1_valid <= 1'b1;
        end else if (w_s1_move) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_write <= w_is_write;
            r_s1_bcond <= r_pred[w_bcond[PRED_AW-1:0]];
            r_s1_scond <= r_pred[w_scond[PRED_AW-1:0]];
            r_s1_fpred <= r_pred[PRED_AW'(FIXED_PRED_IDX)];
        end
    end

    // Result register; a write-back transaction returns all zeros.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_move) begin
            r_out_src1  <= r_s1_write ? '0 : $signed(w_rd1);
            r_out_src2  <= r_s1_write ? '0 : $signed(w_rd2);
            r_out_bcond <= !r_s1_write && r_s1_bcond;
            r_out_scond <= !r_s1_write && r_s1_scond;
            r_out_fpred <= !r_s1_write && r_s1_fpred;
        end
    end

    assign o_res.valid       = r_out_valid;
    assign o_res.src1_value  = r_out_src1;
    assign o_res.src2_value  = r_out_src2;
    assign o_res.bcond_value = r_out_bcond;
    assign o_res.scond_value = r_out_scond;
    assign o_res.fpred_value = r_out_fpred;
endmodule

[verif/slot_result_checker.sv]
// Checker that predicts and compares every result of the VLIW register file.
`timescale 1ns / 1ps
module slot_result_checker (
    input  logic      i_clk,
    input  logic      i_rst_n,
    vrf_op_if         i_op,
    vrf_res_if        i_res,
    output int        o_mismatches,
    output int        o_outstanding,
    output int        o_checked
);
    import vrf_pkg::*;

    typedef struct packed {
        logic [DATA_WIDTH-1:0] src1;
        logic [DATA_WIDTH-1:0] src2;
        logic                  bcond;
        logic                  scond;
        logic                  fpred;
    } t_operand_set;

    // Shadow copy of both register banks.
    logic [DATA_WIDTH-1:0] gp_shadow [NUM_GP_REGS];
    logic                  pred_shadow [NUM_PRED_REGS];

    t_operand_set operands_due[$];
    t_operand_set oldest;

    // True when a register index lies inside the general register file.
    function automatic logic gp_in_range(input logic [REG_IDX_W-1:0] idx);
        return (REG_IDX_W+1)'(idx) < (REG_IDX_W+1)'(NUM_GP_REGS);
    endfunction

    // Applies the slot operation on the operation channel to the shadow banks
    // and returns the operand set that the block must answer with.
    function automatic t_operand_set execute_slot_op();
        t_operand_set          res;
        logic [INSTR_W-1:0]    word;
        logic [REG_IDX_W-1:0]  s1;
        logic [REG_IDX_W-1:0]  s2;
        logic [DATA_WIDTH-1:0] wb_data;
        logic                  wb_ok;
        res  = '0;
        word = i_op.instr_word;
        s1   = word[SRC1_LSB +: REG_IDX_W];
        s2   = word[SRC2_LSB +: REG_IDX_W];
        if (i_op.mode == MODE_READ) begin
            res.src1  = gp_in_range(s1) ? gp_shadow[s1[GP_AW-1:0]] : '0;
            res.src2  = gp_in_range(s2) ? gp_shadow[s2[GP_AW-1:0]] : '0;
            res.bcond = pred_shadow[word[BCOND_LSB +: PRED_IDX_W]];
            res.scond = pred_shadow[word[SCOND_LSB +: PRED_IDX_W]];
            res.fpred = pred_shadow[FIXED_PRED_IDX];
            return res;
        end
        wb_ok   = 1'b1;
        wb_data = '0;
        case (t_wb_src'(i_op.wb_source))
            WB_ALU:  wb_data = i_op.alu_value;
            WB_MEM:  wb_data = i_op.mem_value;
            WB_LINK: wb_data = i_op.pc_value
                               + {{(DATA_WIDTH-BLEN_W){1'b0}}, i_op.bundle_len};
            default: wb_ok = 1'b0;
        endcase
        if (i_op.reg_write && i_op.dest_reg != '0 && wb_ok
                && gp_in_range(i_op.dest_reg)) begin
            gp_shadow[i_op.dest_reg[GP_AW-1:0]] = wb_data;
        end
        // The predicate result only follows an ALU write-back.
        if (i_op.pred_write && t_wb_src'(i_op.wb_source) == WB_ALU) begin
            pred_shadow[i_op.pred_dest] = i_op.alu_pred;
        end
        return res;
    endfunction

    function automatic void compare_field(input string name,
                                          input logic [DATA_WIDTH-1:0] want,
                                          input logic [DATA_WIDTH-1:0] got);
        if (want !== got) begin
            $display("%0t ns: %s mismatch, expected %h, actual %h", $time, name, want, got);
            o_mismatches++;
        end
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_GP_REGS; k++) gp_shadow[k] = '0;
            for (int k = 0; k < NUM_PRED_REGS; k++) pred_shadow[k] = 1'b0;
            operands_due.delete();
            o_outstanding = 0;
        end else begin
            if (i_res.valid && i_res.ready) begin
                if (operands_due.size() == 0) begin
                    $display("%0t ns: result with nothing outstanding, expected none, actual %h %h",
                             $time, i_res.src1_value, i_res.src2_value);
                    o_mismatches++;
                end else begin
                    oldest = operands_due.pop_front();
                    compare_field("src1_value", oldest.src1, i_res.src1_value);
                    compare_field("src2_value", oldest.src2, i_res.src2_value);
                    compare_field("bcond_value", {31'b0, oldest.bcond}, {31'b0, i_res.bcond_value});
                    compare_field("scond_value", {31'b0, oldest.scond}, {31'b0, i_res.scond_value});
                    compare_field("fpred_value", {31'b0, oldest.fpred}, {31'b0, i_res.fpred_value});
                    o_checked++;
                end
            end
            if (i_op.valid && i_op.ready) begin
                operands_due.push_back(execute_slot_op());
            end
            o_outstanding = operands_due.size();
        end
    end

endmodule

[verif/tb_top.sv]
// Top of the register file testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
// The block is driven with slot operations on its operation channel while a
// separate checker watches both channels, keeps its own copy of the general
// and predicate banks and compares every result transaction field by field.
// This module only produces stimulus, shapes the flow on both sides and
// reports the verdict from the checker's mismatch count.
module tb_top;
    import vrf_pkg::*;

    localparam int RANDOM_ITEMS = 1800;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_EVERY  = 400;

    typedef struct {
        t_mode                 mode;
        logic [INSTR_W-1:0]    instr;
        logic [REG_IDX_W-1:0]  dest;
        logic                  reg_wr;
        logic                  pred_wr;
        logic [PRED_IDX_W-1:0] pdest;
        t_wb_src               src;
        logic [DATA_WIDTH-1:0] alu;
        logic                  apred;
        logic [DATA_WIDTH-1:0] mem;
        logic [DATA_WIDTH-1:0] pc;
        logic [BLEN_W-1:0]     blen;
    } t_slot_op;

    typedef enum {
        RX_STREAM,
        RX_COIN,
        RX_PERIODIC,
        RX_LONG_STALL
    } t_rx_style;

    logic i_clk;
    logic i_rst_n;
    int   mismatches;
    int   outstanding;
    int   checked;
    int   cycles;
    int   reads_sent;
    int   writes_sent;

    vrf_op_if  op_if ();
    vrf_res_if res_if ();

    vliw_register_file_with_predicates uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_op    (op_if),
        .o_res   (res_if)
    );

    slot_result_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_op          (op_if),
        .i_res         (res_if),
        .o_mismatches  (mismatches),
        .o_outstanding (outstanding),
        .o_checked     (checked)
    );

    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles with %0d results outstanding.",
                     cycles, outstanding);
            $display("TEST FAILED");
            $finish;
        end
    end

    // The result side cycles through styles of backpressure: streaming,
    // coin-flip stalls, a fixed periodic stall and rare long stalls. Each
    // style holds for a random span so that stalls land on every pipeline
    // phase and some stretches see no backpressure at all.
    initial begin
        t_rx_style style;
        int        span;
        int        tick;
        int        stall_left;
        res_if.ready = 1'b0;
        tick         = 0;
        stall_left   = 0;
        forever begin
            style = t_rx_style'($urandom_range(0, 3));
            span  = $urandom_range(20, 200);
            repeat (span) begin
                @(negedge i_clk);
                tick++;
                case (style)
                    RX_STREAM:   res_if.ready = 1'b1;
                    RX_COIN:     res_if.ready = 1'($urandom_range(0, 1));
                    RX_PERIODIC: res_if.ready = (tick % 5) != 0;
                    default: begin
                        if (stall_left > 0) begin
                            stall_left--;
                            res_if.ready = 1'b0;
                        end else if ($urandom_range(0, 15) == 0) begin
                            stall_left   = $urandom_range(1, 12);
                            res_if.ready = 1'b0;
                        end else begin
                            res_if.ready = 1'b1;
                        end
                    end
                endcase
            end
        end
    end

    // An operand read; the write-back fields carry noise the block must ignore.
    function automatic t_slot_op read_op(input logic [INSTR_W-1:0] word);
        t_slot_op op;
        op.mode    = MODE_READ;
        op.instr   = word;
        op.dest    = REG_IDX_W'($urandom);
        op.reg_wr  = 1'($urandom);
        op.pred_wr = 1'($urandom);
        op.pdest   = PRED_IDX_W'($urandom);
        op.src     = t_wb_src'($urandom_range(0, 3));
        op.alu     = $urandom;
        op.apred   = 1'($urandom);
        op.mem     = $urandom;
        op.pc      = $urandom;
        op.blen    = BLEN_W'($urandom);
        return op;
    endfunction

    // A write-back; the instruction word carries noise.
    function automatic t_slot_op wb_op(input logic [REG_IDX_W-1:0] dest,
                                       input logic reg_wr, input logic pred_wr,
                                       input logic [PRED_IDX_W-1:0] pdest,
                                       input t_wb_src src,
                                       input logic [DATA_WIDTH-1:0] alu,
                                       input logic apred,
                                       input logic [DATA_WIDTH-1:0] mem,
                                       input logic [DATA_WIDTH-1:0] pc,
                                       input logic [BLEN_W-1:0] blen);
        t_slot_op op;
        op.mode    = MODE_WRITE;
        op.instr   = $urandom;
        op.dest    = dest;
        op.reg_wr  = reg_wr;
        op.pred_wr = pred_wr;
        op.pdest   = pdest;
        op.src     = src;
        op.alu     = alu;
        op.apred   = apred;
        op.mem     = mem;
        op.pc      = pc;
        op.blen    = blen;
        return op;
    endfunction

    // Data words lean on the signed and unsigned extremes now and then.
    function automatic logic [DATA_WIDTH-1:0] data_word();
        case ($urandom_range(0, 11))
            0:       return 32'h0000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'h8000_0000;
            3:       return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    // Random slot operation. Reads often name the most recent destination so
    // that a read right behind its write-back is exercised regularly.
    function automatic t_slot_op random_slot_op(input logic [REG_IDX_W-1:0] recent);
        logic [INSTR_W-1:0]   word;
        logic [REG_IDX_W-1:0] dest;
        if ($urandom_range(0, 1) == 0) begin
            word = $urandom;
            if ($urandom_range(0, 2) == 0) word[SRC1_LSB +: REG_IDX_W] = recent;
            if ($urandom_range(0, 2) == 0) word[SRC2_LSB +: REG_IDX_W] = recent;
            return read_op(word);
        end
        dest = ($urandom_range(0, 15) == 0) ? '0 : REG_IDX_W'($urandom_range(1, 63));
        return wb_op(dest, $urandom_range(0, 7) != 0, 1'($urandom_range(0, 1)),
                     PRED_IDX_W'($urandom_range(0, 7)), t_wb_src'($urandom_range(0, 3)),
                     data_word(), 1'($urandom_range(0, 1)), data_word(), data_word(),
                     BLEN_W'($urandom));
    endfunction

    // Presents one transaction from the falling edge and holds it until the
    // block takes it; valid stays high so the next call can follow directly.
    task automatic send_op(input t_slot_op op);
        @(negedge i_clk);
        op_if.valid      = 1'b1;
        op_if.mode       = op.mode;
        op_if.instr_word = op.instr;
        op_if.dest_reg   = op.dest;
        op_if.reg_write  = op.reg_wr;
        op_if.pred_write = op.pred_wr;
        op_if.pred_dest  = op.pdest;
        op_if.wb_source  = op.src;
        op_if.alu_value  = op.alu;
        op_if.alu_pred   = op.apred;
        op_if.mem_value  = op.mem;
        op_if.pc_value   = op.pc;
        op_if.bundle_len = op.blen;
        @(posedge i_clk);
        while (!op_if.ready) @(posedge i_clk);
        if (op.mode == MODE_READ) reads_sent++;
        else writes_sent++;
    endtask

    task automatic pause_cycles(input int n);
        if (n > 0) begin
            @(negedge i_clk);
            op_if.valid = 1'b0;
            repeat (n - 1) @(negedge i_clk);
        end
    endtask

    // Holds off the sender until every issued transaction has been answered.
    task automatic drain();
        @(negedge i_clk);
        op_if.valid = 1'b0;
        while (outstanding != 0) @(negedge i_clk);
    endtask

    initial begin
        t_slot_op             op;
        logic [REG_IDX_W-1:0] last_dest;
        int                   burst_left;
        op_if.valid      = 1'b0;
        op_if.mode       = MODE_READ;
        op_if.instr_word = '0;
        op_if.dest_reg   = '0;
        op_if.reg_write  = 1'b0;
        op_if.pred_write = 1'b0;
        op_if.pred_dest  = '0;
        op_if.wb_source  = WB_ALU;
        op_if.alu_value  = '0;
        op_if.alu_pred   = 1'b0;
        op_if.mem_value  = '0;
        op_if.pc_value   = '0;
        op_if.bundle_len = '0;
        i_rst_n          = 1'b0;
        last_dest        = '0;
        burst_left       = 0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed part. Both banks read as zero right after reset, at the
        // lowest and highest indices.
        send_op(read_op(32'h0000_0000));
        send_op(read_op(32'hFFFF_FFFF));
        // Largest positive ALU value into the top register, predicate seven set.
        send_op(wb_op(6'd63, 1'b1, 1'b1, 3'd7, WB_ALU, 32'h7FFF_FFFF, 1'b1,
                      $urandom, $urandom, BLEN_W'($urandom)));
        // A memory write-back must not touch the predicate bank.
        send_op(wb_op(6'd1, 1'b1, 1'b1, 3'd4, WB_MEM, $urandom, 1'b1,
                      32'h8000_0000, $urandom, BLEN_W'($urandom)));
        // Call link that wraps past the top of the address space.
        send_op(wb_op(6'd2, 1'b1, 1'b1, 3'd3, WB_LINK, $urandom, 1'b1,
                      $urandom, 32'hFFFF_FFF0, 8'hFF));
        // The invalid source writes neither bank.
        send_op(wb_op(6'd3, 1'b1, 1'b1, 3'd2, WB_INVALID, 32'h1234_5678, 1'b1,
                      32'h9ABC_DEF0, $urandom, BLEN_W'($urandom)));
        // Register zero stays zero, while predicate zero is still written.
        send_op(wb_op(6'd0, 1'b1, 1'b1, 3'd0, WB_ALU, 32'hDEAD_BEEF, 1'b1,
                      $urandom, $urandom, BLEN_W'($urandom)));
        // General write disabled; only the fixed predicate four is set.
        send_op(wb_op(6'd5, 1'b0, 1'b1, 3'd4, WB_ALU, 32'hFFFF_FFFF, 1'b1,
                      $urandom, $urandom, BLEN_W'($urandom)));
        send_op(wb_op(6'd6, 1'b1, 1'b0, 3'd5, WB_LINK, $urandom, 1'b1,
                      $urandom, 32'h0000_0000, 8'h00));
        send_op(wb_op(6'd7, 1'b1, 1'b0, 3'd6, WB_ALU, 32'h8000_0000, 1'b1,
                      $urandom, $urandom, BLEN_W'($urandom)));
        send_op(wb_op(6'd8, 1'b1, 1'b0, 3'd1, WB_MEM, $urandom, 1'b0,
                      32'hFFFF_FFFF, $urandom, BLEN_W'($urandom)));
        send_op(wb_op(6'd9, 1'b1, 1'b1, 3'd6, WB_LINK, $urandom, 1'b1,
                      $urandom, 32'hFFFF_FFFF, 8'h01));
        // Reads across the written registers with varied predicate selects;
        // note that bcond and scond share bit 23 of the instruction word.
        send_op(read_op(32'h0000_007F));
        send_op(read_op(32'h0200_0081));
        send_op(read_op(32'h03E0_0003));
        send_op(read_op(32'h0080_0185));
        send_op(read_op(32'h0020_0247));
        send_op(read_op(32'hFC00_0200));
        send_op(read_op(32'h0000_0249));
        // Clear predicate seven again and read everything at the top index.
        send_op(wb_op(6'd63, 1'b0, 1'b1, 3'd7, WB_ALU, $urandom, 1'b0,
                      $urandom, $urandom, BLEN_W'($urandom)));
        send_op(read_op(32'hFFFF_FFFF));
        drain();

        // Random part: bursts of random length separated by random gaps,
        // with zero-length gaps giving stretches of back-to-back traffic.
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (burst_left == 0) begin
                pause_cycles(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8));
                burst_left = $urandom_range(1, 40);
            end
            op = random_slot_op(last_dest);
            send_op(op);
            if (op.mode == MODE_WRITE) last_dest = op.dest;
            burst_left--;
            if (n % DRAIN_EVERY == DRAIN_EVERY - 1) drain();
        end

        drain();
        repeat (8) @(negedge i_clk);
        $display("Covered %0d operand reads and %0d write-backs; %0d results compared.",
                 reads_sent, writes_sent, checked);
        if (mismatches == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("%0d mismatches found.", mismatches);
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
